// ----- hw/rtl/olse_pkg.sv -----
package olse_pkg;

   typedef enum logic [3:0] {
      OP_INS_HEAD   = 4'd0,
      OP_INS_TAIL   = 4'd1,
      OP_INS_BEFORE = 4'd2,
      OP_INS_AFTER  = 4'd3,
      OP_INS_AT     = 4'd4,
      OP_RM_HEAD    = 4'd5,
      OP_RM_TAIL    = 4'd6,
      OP_RM_AFTER   = 4'd7,
      OP_RM_BEFORE  = 4'd8,
      OP_RM_AT      = 4'd9,
      OP_FIND       = 4'd10,
      OP_CLEAR      = 4'd11
   } op_type;

   typedef enum logic [1:0] {
      ST_DONE     = 2'd0,
      ST_NOTFOUND = 2'd1,
      ST_FULL     = 2'd2,
      ST_NOTHING  = 2'd3
   } status_type;

   typedef enum logic {
      CTL_IDLE = 1'b0,
      CTL_EXEC = 1'b1
   } ctl_state_type;

   // controller -> datapath
   typedef struct packed {
      logic capture;   // latch command, compare all cells
      logic execute;   // apply edit, load result register
   } cmd_type;

   localparam int KEY_W = 32;
   localparam int POS_W = 8;
   localparam int OUT_W = 7;

endpackage

// ----- hw/rtl/ordered_list_store_editor.sv -----
// Channel  Dir  Ports      Contents (low bit up)
// req      in   req_t*     tuser: operation[3:0]; tdata: new_value, match_key, position
// rsp      out  rsp_t*     tdata: status, found_position, new_length
//
// Each command has a capture step that compares match_key in
// every cell at once, and an execute step that finds the first match and
// shifts the cells by one place. One command is in flight at a time.
// Reset clears the length; cell contents are undefined until written.
// A stalled result holds the next command in execute; req_tready is high
// in capture even while the previous result still waits for rsp_tready.
module ordered_list_store_editor
   import olse_pkg::*;
#(
   parameter int CAPACITY = 64
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [79:0] req_tdata,   // new_value[31:0], match_key[63:32], position[71:64], 0
   input  logic [3:0]  req_tuser,   // operation[3:0]
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [15:0] rsp_tdata    // status[1:0], found_position[8:2], new_length[15:9]
);

   cmd_type          cmd;
   status_type       status;
   logic [OUT_W-1:0] found_position;
   logic [OUT_W-1:0] new_length;

   olse_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tready (rsp_tready),
      .rsp_tvalid (rsp_tvalid),
      .cmd        (cmd)
   );

   olse_datapath #(
      .CAPACITY (CAPACITY)
   ) u_datapath (
      .clock              (clock),
      .reset              (reset),
      .cmd                (cmd),
      .req_op             (op_type'(req_tuser)),
      .req_new_value      (req_tdata[31:0]),
      .req_match_key      (req_tdata[63:32]),
      .req_position       (req_tdata[71:64]),
      .rsp_status         (status),
      .rsp_found_position (found_position),
      .rsp_new_length     (new_length)
   );

   assign rsp_tdata = {new_length, found_position, status};

endmodule

// ----- hw/rtl/olse_ctrl.sv -----
module olse_ctrl
   import olse_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    req_tvalid,
   output logic    req_tready,
   input  logic    rsp_tready,
   output logic    rsp_tvalid,
   output cmd_type cmd
);

   ctl_state_type state_ff, state_in;
   logic          rsp_valid_ff, rsp_valid_in;
   logic          slot_free;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= CTL_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_comb begin
      slot_free    = !rsp_valid_ff || rsp_tready;
      state_in     = state_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      cmd          = '0;
      req_tready   = 1'b0;
      unique case (state_ff)
         CTL_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               cmd.capture = 1'b1;
               state_in    = CTL_EXEC;
            end
         end
         CTL_EXEC: begin
            if (slot_free) begin
               cmd.execute  = 1'b1;
               rsp_valid_in = 1'b1;
               state_in     = CTL_IDLE;
            end
         end
         default: state_in = CTL_IDLE;
      endcase
   end

   assign rsp_tvalid = rsp_valid_ff;

endmodule

// ----- hw/rtl/olse_datapath.sv -----
module olse_datapath
   import olse_pkg::*;
#(
   parameter int CAPACITY = 64
) (
   input  logic                    clock,
   input  logic                    reset,
   input  cmd_type                 cmd,
   input  op_type                  req_op,
   input  logic [KEY_W-1:0]        req_new_value,
   input  logic [KEY_W-1:0]        req_match_key,
   input  logic [POS_W-1:0]        req_position,
   output status_type              rsp_status,
   output logic [OUT_W-1:0]        rsp_found_position,
   output logic [OUT_W-1:0]        rsp_new_length
);

   localparam int CW = $clog2(CAPACITY + 1);
   localparam int IW = $clog2(CAPACITY);
   localparam int EW = ((CW > POS_W) ? CW : POS_W) + 1;

   logic [KEY_W-1:0]    key_ff [CAPACITY];
   logic [KEY_W-1:0]    key_in [CAPACITY];
   logic [KEY_W-1:0]    key_prev [CAPACITY];
   logic [KEY_W-1:0]    key_next [CAPACITY];
   logic [CW-1:0]       count_ff, count_in;
   logic [CAPACITY-1:0] match_ff, match_in;

   op_type              op_ff;
   logic [KEY_W-1:0]    nv_ff;
   logic [POS_W-1:0]    pos_ff;

   status_type          status_ff, status_in;
   logic [OUT_W-1:0]    fp_ff, fp_in;
   logic [OUT_W-1:0]    len_ff;

   logic [CAPACITY-1:0] first_oh;
   logic [IW-1:0]       idx;
   logic [CW-1:0]       idx_w;
   logic                hit, full, empty;
   logic [EW-1:0]       pos_e, count_e;
   logic                do_ins, do_rm, do_clr;
   logic [CW-1:0]       ins_idx, rm_idx;

   // neighbor taps for the shift
   for (genvar g = 0; g < CAPACITY; g++) begin : g_tap
      if (g == 0) begin : g_first
         assign key_prev[g] = key_ff[g];
      end else begin : g_mid
         assign key_prev[g] = key_ff[g-1];
      end
      if (g == CAPACITY - 1) begin : g_last
         assign key_next[g] = key_ff[g];
      end else begin : g_body
         assign key_next[g] = key_ff[g+1];
      end
   end

   // per-cell compare at capture
   always_comb begin
      for (int i = 0; i < CAPACITY; i++) begin
         match_in[i] = (key_ff[i] == req_match_key) && (CW'(i) < count_ff);
      end
   end

   // first match: isolate lowest set bit, then OR its index
   always_comb begin
      first_oh = match_ff & (~match_ff + CAPACITY'(1));
      idx      = '0;
      for (int i = 0; i < CAPACITY; i++) begin
         idx = idx | (first_oh[i] ? IW'(i) : '0);
      end
   end

   always_comb begin
      hit     = |match_ff;
      idx_w   = CW'(idx);
      full    = (count_ff == CW'(CAPACITY));
      empty   = (count_ff == '0);
      pos_e   = EW'(pos_ff);
      count_e = EW'(count_ff);

      status_in = ST_DONE;
      fp_in     = '0;
      do_ins    = 1'b0;
      do_rm     = 1'b0;
      do_clr    = 1'b0;
      ins_idx   = '0;
      rm_idx    = '0;

      unique case (op_ff)
         OP_INS_HEAD: begin
            if (full) status_in = ST_FULL;
            else do_ins = 1'b1;
         end
         OP_INS_TAIL: begin
            if (full) status_in = ST_FULL;
            else begin
               do_ins  = 1'b1;
               ins_idx = count_ff;
            end
         end
         OP_INS_BEFORE, OP_INS_AFTER: begin
            if (full) status_in = ST_FULL;
            else if (empty) do_ins = 1'b1;
            else if (!hit) status_in = ST_NOTFOUND;
            else begin
               do_ins  = 1'b1;
               ins_idx = (op_ff == OP_INS_AFTER) ? idx_w + CW'(1) : idx_w;
            end
         end
         OP_INS_AT: begin
            if (full) status_in = ST_FULL;
            else if (pos_e == '0 || pos_e > count_e + EW'(1)) status_in = ST_NOTFOUND;
            else begin
               do_ins  = 1'b1;
               ins_idx = CW'(pos_e - EW'(1));
            end
         end
         OP_RM_HEAD: begin
            if (empty) status_in = ST_NOTHING;
            else do_rm = 1'b1;
         end
         OP_RM_TAIL: begin
            if (empty) status_in = ST_NOTHING;
            else begin
               do_rm  = 1'b1;
               rm_idx = count_ff - CW'(1);
            end
         end
         OP_RM_AFTER: begin
            if (empty) status_in = ST_NOTHING;
            else if (!hit) status_in = ST_NOTFOUND;
            else if (idx_w + CW'(1) >= count_ff) status_in = ST_NOTHING;
            else begin
               do_rm  = 1'b1;
               rm_idx = idx_w + CW'(1);
            end
         end
         OP_RM_BEFORE: begin
            if (empty) status_in = ST_NOTHING;
            else if (!hit) status_in = ST_NOTFOUND;
            else if (idx_w == '0) status_in = ST_NOTHING;
            else begin
               do_rm  = 1'b1;
               rm_idx = idx_w - CW'(1);
            end
         end
         OP_RM_AT: begin
            if (empty) status_in = ST_NOTHING;
            else if (pos_e == '0 || pos_e > count_e) status_in = ST_NOTFOUND;
            else begin
               do_rm  = 1'b1;
               rm_idx = CW'(pos_e - EW'(1));
            end
         end
         OP_FIND: begin
            if (!hit) status_in = ST_NOTFOUND;
            else fp_in = OUT_W'(idx_w + CW'(1));
         end
         OP_CLEAR: do_clr = 1'b1;
         default: ;
      endcase
   end

   // cell shift and length update
   always_comb begin
      count_in = count_ff;
      for (int i = 0; i < CAPACITY; i++) begin
         key_in[i] = key_ff[i];
         if (cmd.execute && do_ins) begin
            if (CW'(i) == ins_idx) key_in[i] = nv_ff;
            else if (CW'(i) > ins_idx) key_in[i] = key_prev[i];
         end else if (cmd.execute && do_rm) begin
            if (CW'(i) >= rm_idx) key_in[i] = key_next[i];
         end
      end
      if (cmd.execute) begin
         if (do_clr) count_in = '0;
         else if (do_ins) count_in = count_ff + CW'(1);
         else if (do_rm) count_in = count_ff - CW'(1);
      end
   end

   always_ff @(posedge clock) begin
      for (int i = 0; i < CAPACITY; i++) key_ff[i] <= key_in[i];
      if (cmd.capture) begin
         op_ff    <= req_op;
         nv_ff    <= req_new_value;
         pos_ff   <= req_position;
         match_ff <= match_in;
      end
      if (cmd.execute) begin
         status_ff <= status_in;
         fp_ff     <= fp_in;
         len_ff    <= OUT_W'(count_in);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) count_ff <= '0;
      else       count_ff <= count_in;
   end

   assign rsp_status         = status_ff;
   assign rsp_found_position = fp_ff;
   assign rsp_new_length     = len_ff;

`ifndef SYNTHESIS
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CW'(CAPACITY))
      else $error("list length above capacity");
   a_full_holds: assert property (@(posedge clock) disable iff (reset)
      cmd.execute && status_in == ST_FULL |=> count_ff == CW'(CAPACITY))
      else $error("full insert changed length");
   a_fail_stable: assert property (@(posedge clock) disable iff (reset)
      cmd.execute && status_in != ST_DONE |=> $stable(count_ff))
      else $error("failed edit changed length");
   a_no_overlap: assert property (@(posedge clock) disable iff (reset)
      !(cmd.capture && cmd.execute))
      else $error("capture and execute together");
`endif

endmodule
